FILE: rtl/ugb_pkg.sv
// ugb_pkg: shared codes and field widths of the uniform grid bucket engine
// no dependencies; used by uniform_grid_bucket_engine
package ugb_pkg;

    typedef enum logic [1:0] {
        OP_ADD    = 2'd0,
        OP_REMOVE = 2'd1,
        OP_QUERY  = 2'd2,
        OP_CLEAR  = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_OUTSIDE   = 2'd1,
        ST_FULL      = 2'd2,
        ST_NOT_FOUND = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        REG_ORIGIN_X  = 3'd0,
        REG_ORIGIN_Y  = 3'd1,
        REG_CELL_SIZE = 3'd2,
        REG_GRID_ROWS = 3'd3,
        REG_GRID_COLS = 3'd4
    } reg_idx_t;

    localparam int POS_W      = 24;
    localparam int SIZE_W     = 23;
    localparam int GRID_W     = 7;
    localparam int PID_W      = 16;
    localparam int RC_W       = 6;
    localparam int RESULT_MAX = 40;
    localparam int NBR_CELLS  = 5;

endpackage

FILE: rtl/uniform_grid_bucket_engine.sv
// uniform_grid_bucket_engine: uniform-grid broad phase with bucket memories
// depends on ugb_pkg
//
// usage: one request enters on the s_axis channel (op in tuser), results leave on
// m_axis with tlast on the final one. configuration is written through cfg_we,
// cfg_addr and cfg_data while the block is idle.
// add: bit-serial divide of x and y offsets by the cell size, then a range
//   check, a count read and, if the bucket has room, one write, to its single result
// remove: a count read, then a read and a compare per bucket slot scanned
//   and a read and a write per slot shifted down
// query: up to five cells, a read, compare and advance step per slot, one
//   result per found id (at most 40), or one without an id if none is found; a
//   found id is held back one step so the final one can carry tlast
// clear: one bucket count zeroed per cycle over all MAX_ROWS*MAX_COLS cells
// after reset the same sweep runs over all MAX_ROWS*MAX_COLS cells (4096 by default)
// with s_axis_tready low; configuration writes are taken meanwhile
// one request is worked on at a time; the memory ports set the pace
// the result sits in an output register; a stalled receiver holds the
// sequencer until it is taken
module uniform_grid_bucket_engine #(
    parameter int MAX_ROWS   = 64,
    parameter int MAX_COLS   = 64,
    parameter int BUCKET_CAP = 8,
    parameter int ID_BITS    = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // particle_id[15:0], pos_x[39:16], pos_y[63:40], cell_row[69:64],
    // cell_col[75:70], zero[79:76]
    input  logic [79:0] s_axis_tdata,
    // op[1:0]
    input  logic [1:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // neighbour_id[15:0], bin_row[21:16], bin_col[27:22], status[29:28], zero[31:30]
    output logic [31:0] m_axis_tdata,
    // has_id[0]
    output logic [0:0]  m_axis_tuser,
    output logic        m_axis_tlast,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_addr,
    input  logic [23:0] cfg_data
);

    localparam int CELLS = MAX_ROWS * MAX_COLS;
    localparam int CW    = (CELLS > 1) ? $clog2(CELLS) : 1;
    localparam int SLOTS = CELLS * BUCKET_CAP;
    localparam int IAW   = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int NW    = $clog2(BUCKET_CAP + 1);
    localparam int LW    = 11;
    localparam int PW    = ugb_pkg::POS_W;
    localparam int SW    = ugb_pkg::SIZE_W;

    typedef enum logic [4:0] {
        S_CLR, S_IDLE, S_DIV, S_A_RANGE, S_A_WAIT, S_A_CHK,
        S_R_WAIT, S_R_LOOK, S_R_RD, S_R_CMP, S_SH_RD, S_SH_WR,
        S_Q_CELL, S_Q_WAIT, S_Q_N, S_Q_RD, S_Q_CMP, S_Q_ADV, S_EMIT
    } state_t;

    // memories
    logic [NW-1:0]      cnt_mem [CELLS];
    logic [ID_BITS-1:0] id_mem  [SLOTS];
    logic [NW-1:0]      cnt_q;
    logic [ID_BITS-1:0] id_q;

    logic               cnt_we;
    logic [CW-1:0]      cnt_waddr;
    logic [NW-1:0]      cnt_wdata;
    logic               id_we;
    logic [IAW-1:0]     id_waddr;
    logic [ID_BITS-1:0] id_wdata;
    logic [IAW-1:0]     id_raddr;

    state_t state_reg, ret_reg;

    logic signed [PW-1:0] origin_x_reg, origin_y_reg;
    logic [SW-1:0]        cell_size_reg;
    logic [6:0]           grid_rows_reg, grid_cols_reg;

    logic [ID_BITS-1:0]   pid_reg;
    logic [5:0]           row_reg, col_reg;
    logic [CW-1:0]        cell_reg;
    logic [CW-1:0]        clr_idx_reg;
    logic                 clr_op_reg;
    logic [NW-1:0]        n_reg, idx_reg;
    logic [2:0]           v_reg;
    logic [5:0]           k_reg;
    logic                 pend_valid_reg;
    logic [ID_BITS-1:0]   pend_id_reg;

    logic [PW-1:0]        xq_reg, yq_reg;
    logic [SW-1:0]        xrem_reg, yrem_reg;
    logic [4:0]           div_cnt_reg;

    logic [ID_BITS-1:0]   res_id_reg;
    logic                 res_has_reg, res_last_reg;
    logic [5:0]           res_row_reg, res_col_reg;
    logic [1:0]           res_status_reg;

    logic                 m_valid_reg, m_last_reg, m_has_reg;
    logic [31:0]          m_data_reg;

    // in-use grid size
    logic [LW-1:0] nr, nc;
    assign nr = (LW'(grid_rows_reg) < LW'(MAX_ROWS)) ? LW'(grid_rows_reg) : LW'(MAX_ROWS);
    assign nc = (LW'(grid_cols_reg) < LW'(MAX_COLS)) ? LW'(grid_cols_reg) : LW'(MAX_COLS);

    // input fields
    logic [ID_BITS-1:0]    in_pid;
    logic signed [PW:0]    in_rx, in_ry;
    logic [5:0]            in_row, in_col;
    assign in_pid = ID_BITS'(s_axis_tdata[15:0]);
    assign in_rx  = $signed({s_axis_tdata[39], s_axis_tdata[39:16]})
                  - $signed({origin_x_reg[PW-1], origin_x_reg});
    assign in_ry  = $signed({s_axis_tdata[63], s_axis_tdata[63:40]})
                  - $signed({origin_y_reg[PW-1], origin_y_reg});
    assign in_row = s_axis_tdata[69:64];
    assign in_col = s_axis_tdata[75:70];

    // restoring divide step, x and y side by side
    logic [SW:0]   x_sh, y_sh;
    logic          x_ge, y_ge;
    assign x_sh = {xrem_reg, xq_reg[PW-1]};
    assign y_sh = {yrem_reg, yq_reg[PW-1]};
    assign x_ge = x_sh >= {1'b0, cell_size_reg};
    assign y_ge = y_sh >= {1'b0, cell_size_reg};

    // neighbour cell of the query walk
    logic signed [7:0] d_r, d_c, q_r, q_c;
    logic              q_ok;
    always_comb
    begin
        case (v_reg)
            3'd0:    begin d_r = -8'sd1; d_c = -8'sd1; end
            3'd1:    begin d_r = -8'sd1; d_c = 8'sd0;  end
            3'd2:    begin d_r = 8'sd0;  d_c = -8'sd1; end
            3'd3:    begin d_r = 8'sd0;  d_c = 8'sd0;  end
            3'd4:    begin d_r = 8'sd1;  d_c = -8'sd1; end
            default: begin d_r = 8'sd0;  d_c = 8'sd0;  end
        endcase
        q_r  = $signed({2'b00, row_reg}) + d_r;
        q_c  = $signed({2'b00, col_reg}) + d_c;
        q_ok = !q_r[7] && !q_c[7] && (LW'(q_r[6:0]) < nr) && (LW'(q_c[6:0]) < nc);
    end

    logic [IAW-1:0] slot_base;
    assign slot_base = IAW'(IAW'(cell_reg) * IAW'(BUCKET_CAP));

    // memory port control
    always_comb
    begin
        cnt_we    = 1'b0;
        cnt_waddr = cell_reg;
        cnt_wdata = '0;
        id_we     = 1'b0;
        id_waddr  = IAW'(slot_base + IAW'(idx_reg));
        id_wdata  = id_q;
        id_raddr  = IAW'(slot_base + IAW'(idx_reg));
        case (state_reg)
            S_CLR:
            begin
                cnt_we    = 1'b1;
                cnt_waddr = clr_idx_reg;
            end
            S_A_CHK:
            begin
                if (cnt_q < NW'(BUCKET_CAP))
                begin
                    cnt_we    = 1'b1;
                    cnt_wdata = NW'(cnt_q + 1'b1);
                    id_we     = 1'b1;
                    id_waddr  = IAW'(slot_base + IAW'(cnt_q));
                    id_wdata  = pid_reg;
                end
            end
            S_R_CMP:
            begin
                if (id_q == pid_reg && NW'(idx_reg + 1'b1) >= n_reg)
                begin
                    cnt_we    = 1'b1;
                    cnt_wdata = NW'(n_reg - 1'b1);
                end
            end
            S_SH_RD:
            begin
                id_raddr = IAW'(slot_base + IAW'(idx_reg) + IAW'(1));
            end
            S_SH_WR:
            begin
                id_we = 1'b1;
                if (NW'(idx_reg + 2'd2) >= n_reg)
                begin
                    cnt_we    = 1'b1;
                    cnt_wdata = NW'(n_reg - 1'b1);
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cnt_we)
        begin
            cnt_mem[cnt_waddr] <= cnt_wdata;
        end
        cnt_q <= cnt_mem[cell_reg];
    end

    always_ff @(posedge clk)
    begin
        if (id_we)
        begin
            id_mem[id_waddr] <= id_wdata;
        end
        id_q <= id_mem[id_raddr];
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            origin_x_reg  <= '0;
            origin_y_reg  <= '0;
            cell_size_reg <= SW'(256);
            grid_rows_reg <= 7'd64;
            grid_cols_reg <= 7'd64;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                ugb_pkg::REG_ORIGIN_X:  origin_x_reg  <= $signed(cfg_data);
                ugb_pkg::REG_ORIGIN_Y:  origin_y_reg  <= $signed(cfg_data);
                ugb_pkg::REG_CELL_SIZE: cell_size_reg <= cfg_data[SW-1:0];
                ugb_pkg::REG_GRID_ROWS: grid_rows_reg <= cfg_data[6:0];
                ugb_pkg::REG_GRID_COLS: grid_cols_reg <= cfg_data[6:0];
                default: ;
            endcase
        end
    end

    // sequencer and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_CLR;
            ret_reg        <= S_IDLE;
            clr_idx_reg    <= '0;
            clr_op_reg     <= 1'b0;
            pend_valid_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end
        else
        begin
            if (m_valid_reg && m_axis_tready && state_reg != S_EMIT)
            begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_CLR:
                begin
                    if (clr_idx_reg == CW'(CELLS - 1))
                    begin
                        clr_idx_reg <= '0;
                        if (clr_op_reg)
                        begin
                            res_status_reg <= ugb_pkg::ST_OK;
                            ret_reg        <= S_IDLE;
                            state_reg      <= S_EMIT;
                        end
                        else
                        begin
                            state_reg <= S_IDLE;
                        end
                    end
                    else
                    begin
                        clr_idx_reg <= CW'(clr_idx_reg + 1'b1);
                    end
                end
                S_IDLE:
                begin
                    res_id_reg     <= '0;
                    res_has_reg    <= 1'b0;
                    res_row_reg    <= '0;
                    res_col_reg    <= '0;
                    res_last_reg   <= 1'b1;
                    ret_reg        <= S_IDLE;
                    if (s_axis_tvalid)
                    begin
                        pid_reg <= in_pid;
                        row_reg <= in_row;
                        col_reg <= in_col;
                        case (s_axis_tuser)
                            ugb_pkg::OP_ADD:
                            begin
                                if (cell_size_reg == '0 || in_rx[PW] || in_ry[PW])
                                begin
                                    res_status_reg <= ugb_pkg::ST_OUTSIDE;
                                    state_reg      <= S_EMIT;
                                end
                                else
                                begin
                                    res_status_reg <= ugb_pkg::ST_OK;
                                    xq_reg      <= in_rx[PW-1:0];
                                    yq_reg      <= in_ry[PW-1:0];
                                    xrem_reg    <= '0;
                                    yrem_reg    <= '0;
                                    div_cnt_reg <= '0;
                                    state_reg   <= S_DIV;
                                end
                            end
                            ugb_pkg::OP_REMOVE:
                            begin
                                if (LW'(in_row) >= nr || LW'(in_col) >= nc)
                                begin
                                    res_status_reg <= ugb_pkg::ST_OUTSIDE;
                                    state_reg      <= S_EMIT;
                                end
                                else
                                begin
                                    res_status_reg <= ugb_pkg::ST_OK;
                                    cell_reg  <= CW'(CW'(in_row) * CW'(MAX_COLS) + CW'(in_col));
                                    state_reg <= S_R_WAIT;
                                end
                            end
                            ugb_pkg::OP_QUERY:
                            begin
                                res_status_reg <= ugb_pkg::ST_OK;
                                v_reg          <= '0;
                                k_reg          <= '0;
                                pend_valid_reg <= 1'b0;
                                state_reg      <= S_Q_CELL;
                            end
                            default:
                            begin
                                res_status_reg <= ugb_pkg::ST_OK;
                                clr_op_reg  <= 1'b1;
                                clr_idx_reg <= '0;
                                state_reg   <= S_CLR;
                            end
                        endcase
                    end
                end
                S_DIV:
                begin
                    xrem_reg    <= x_ge ? SW'(x_sh - {1'b0, cell_size_reg}) : x_sh[SW-1:0];
                    yrem_reg    <= y_ge ? SW'(y_sh - {1'b0, cell_size_reg}) : y_sh[SW-1:0];
                    xq_reg      <= {xq_reg[PW-2:0], x_ge};
                    yq_reg      <= {yq_reg[PW-2:0], y_ge};
                    div_cnt_reg <= 5'(div_cnt_reg + 1'b1);
                    if (div_cnt_reg == 5'(PW - 1))
                    begin
                        state_reg <= S_A_RANGE;
                    end
                end
                S_A_RANGE:
                begin
                    if (yq_reg >= PW'(nr) || xq_reg >= PW'(nc))
                    begin
                        res_status_reg <= ugb_pkg::ST_OUTSIDE;
                        state_reg      <= S_EMIT;
                    end
                    else
                    begin
                        cell_reg    <= CW'(CW'(yq_reg) * CW'(MAX_COLS) + CW'(xq_reg));
                        res_row_reg <= yq_reg[5:0];
                        res_col_reg <= xq_reg[5:0];
                        state_reg   <= S_A_WAIT;
                    end
                end
                S_A_WAIT:
                begin
                    state_reg <= S_A_CHK;
                end
                S_A_CHK:
                begin
                    res_status_reg <= (cnt_q < NW'(BUCKET_CAP)) ? ugb_pkg::ST_OK
                                                                : ugb_pkg::ST_FULL;
                    state_reg      <= S_EMIT;
                end
                S_R_WAIT:
                begin
                    state_reg <= S_R_LOOK;
                end
                S_R_LOOK:
                begin
                    n_reg   <= cnt_q;
                    idx_reg <= '0;
                    if (cnt_q == '0)
                    begin
                        res_status_reg <= ugb_pkg::ST_NOT_FOUND;
                        state_reg      <= S_EMIT;
                    end
                    else
                    begin
                        state_reg <= S_R_RD;
                    end
                end
                S_R_RD:
                begin
                    state_reg <= S_R_CMP;
                end
                S_R_CMP:
                begin
                    if (id_q == pid_reg)
                    begin
                        if (NW'(idx_reg + 1'b1) >= n_reg)
                        begin
                            state_reg <= S_EMIT;
                        end
                        else
                        begin
                            state_reg <= S_SH_RD;
                        end
                    end
                    else if (NW'(idx_reg + 1'b1) < n_reg)
                    begin
                        idx_reg   <= NW'(idx_reg + 1'b1);
                        state_reg <= S_R_RD;
                    end
                    else
                    begin
                        res_status_reg <= ugb_pkg::ST_NOT_FOUND;
                        state_reg      <= S_EMIT;
                    end
                end
                S_SH_RD:
                begin
                    state_reg <= S_SH_WR;
                end
                S_SH_WR:
                begin
                    idx_reg <= NW'(idx_reg + 1'b1);
                    if (NW'(idx_reg + 2'd2) >= n_reg)
                    begin
                        state_reg <= S_EMIT;
                    end
                    else
                    begin
                        state_reg <= S_SH_RD;
                    end
                end
                S_Q_CELL:
                begin
                    if (v_reg == 3'(ugb_pkg::NBR_CELLS))
                    begin
                        res_id_reg   <= pend_valid_reg ? pend_id_reg : '0;
                        res_has_reg  <= pend_valid_reg;
                        res_last_reg <= 1'b1;
                        ret_reg      <= S_IDLE;
                        state_reg    <= S_EMIT;
                    end
                    else if (q_ok)
                    begin
                        cell_reg  <= CW'(CW'(q_r[6:0]) * CW'(MAX_COLS) + CW'(q_c[6:0]));
                        state_reg <= S_Q_WAIT;
                    end
                    else
                    begin
                        v_reg <= 3'(v_reg + 1'b1);
                    end
                end
                S_Q_WAIT:
                begin
                    state_reg <= S_Q_N;
                end
                S_Q_N:
                begin
                    n_reg   <= cnt_q;
                    idx_reg <= '0;
                    if (cnt_q == '0)
                    begin
                        v_reg     <= 3'(v_reg + 1'b1);
                        state_reg <= S_Q_CELL;
                    end
                    else
                    begin
                        state_reg <= S_Q_RD;
                    end
                end
                S_Q_RD:
                begin
                    state_reg <= S_Q_CMP;
                end
                S_Q_CMP:
                begin
                    if (id_q != pid_reg)
                    begin
                        // send the held-back id, keep the new one
                        if (pend_valid_reg)
                        begin
                            res_id_reg   <= pend_id_reg;
                            res_has_reg  <= 1'b1;
                            res_last_reg <= 1'b0;
                            ret_reg      <= S_Q_ADV;
                            state_reg    <= S_EMIT;
                        end
                        else
                        begin
                            state_reg <= S_Q_ADV;
                        end
                        pend_id_reg    <= id_q;
                        pend_valid_reg <= 1'b1;
                        k_reg          <= 6'(k_reg + 1'b1);
                    end
                    else
                    begin
                        state_reg <= S_Q_ADV;
                    end
                end
                S_Q_ADV:
                begin
                    if (k_reg == 6'(ugb_pkg::RESULT_MAX))
                    begin
                        res_id_reg   <= pend_id_reg;
                        res_has_reg  <= 1'b1;
                        res_last_reg <= 1'b1;
                        ret_reg      <= S_IDLE;
                        state_reg    <= S_EMIT;
                    end
                    else if (NW'(idx_reg + 1'b1) < n_reg)
                    begin
                        idx_reg   <= NW'(idx_reg + 1'b1);
                        state_reg <= S_Q_RD;
                    end
                    else
                    begin
                        v_reg     <= 3'(v_reg + 1'b1);
                        state_reg <= S_Q_CELL;
                    end
                end
                S_EMIT:
                begin
                    if (!m_valid_reg || m_axis_tready)
                    begin
                        m_valid_reg <= 1'b1;
                        m_data_reg  <= {2'b00, res_status_reg, res_col_reg, res_row_reg,
                                        16'(res_id_reg)};
                        m_has_reg   <= res_has_reg;
                        m_last_reg  <= res_last_reg;
                        if (ret_reg == S_IDLE)
                        begin
                            clr_op_reg <= 1'b0;
                        end
                        state_reg   <= ret_reg;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign s_axis_tready   = (state_reg == S_IDLE);
    assign m_axis_tvalid   = m_valid_reg;
    assign m_axis_tdata    = m_data_reg;
    assign m_axis_tuser[0] = m_has_reg;
    assign m_axis_tlast    = m_last_reg;

endmodule
